@@ src/rhc_pkg.sv @@
package rhc_pkg;

	// Default conversion precision
	localparam int DEF_HUE_FRAC_BITS = 6;
	localparam int DEF_SAT_BITS      = 16;

	// Channel byte, divisor (twice a byte) and sector numerator widths
	localparam int CH_W  = 8;
	localparam int DEN_W = CH_W + 1;
	localparam int T_W   = 11;

	// Quotient bits retired by each divider stage
	localparam int STEP_BITS = 4;

	// Hue scaling: 60 degrees per sector, doubled for round-to-nearest
	localparam int HUE_DEG_TURN = 360;
	localparam int HUE_MULT     = 120;

endpackage

@@ src/rhc_front.sv @@
module rhc_front #(
	parameter int HUE_FRAC_BITS = rhc_pkg::DEF_HUE_FRAC_BITS,
	parameter int SAT_BITS      = rhc_pkg::DEF_SAT_BITS,
	parameter int QPAD          = 16
) (
	input  logic                      clk,
	input  logic                      en_s1,
	input  logic                      en_s2,
	input  logic [rhc_pkg::CH_W-1:0]  red,
	input  logic [rhc_pkg::CH_W-1:0]  green,
	input  logic [rhc_pkg::CH_W-1:0]  blue,
	output logic [rhc_pkg::DEN_W-1:0] sat_rem_s2,
	output logic [QPAD-1:0]           sat_work_s2,
	output logic [rhc_pkg::DEN_W-1:0] sat_den_s2,
	output logic [rhc_pkg::DEN_W-1:0] hue_rem_s2,
	output logic [QPAD-1:0]           hue_work_s2,
	output logic [rhc_pkg::DEN_W-1:0] hue_den_s2,
	output logic [rhc_pkg::CH_W-1:0]  bright_s2,
	output logic                      zero_s2
);
	import rhc_pkg::*;

	localparam int NX = QPAD + DEN_W;

	logic [CH_W-1:0] mx, mn, c;
	logic [T_W-1:0]  c11, t;
	logic [CH_W-1:0] mx_s1, c_s1;
	logic [T_W-1:0]  t_s1;
	logic [NX-1:0]   num_sat, num_hue;

	// Max, min, chroma and the sector position scaled by chroma
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		c   = mx - mn;
		c11 = T_W'(c);
		if (mx == red) begin
			if (green >= blue) t = T_W'(green - blue);
			else t = (c11 << 2) + (c11 << 1) - T_W'(blue - green);
		end else if (mx == green) begin
			t = (c11 << 1) + T_W'(blue) - T_W'(red);
		end else begin
			t = (c11 << 2) + T_W'(red) - T_W'(green);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mx_s1 <= mx;
			c_s1  <= c;
			t_s1  <= t;
		end
	end

	// Rounded dividends: 2*c*full + mx over 2*mx, 2*scale*t + c over 2*c
	always_comb begin
		num_sat = (NX'(c_s1) << (SAT_BITS + 1)) - (NX'(c_s1) << 1) + NX'(mx_s1);
		num_hue = ((NX'(t_s1) * NX'(HUE_MULT)) << HUE_FRAC_BITS) + NX'(c_s1);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sat_rem_s2  <= num_sat[NX-1:QPAD];
			sat_work_s2 <= num_sat[QPAD-1:0];
			sat_den_s2  <= {mx_s1, 1'b0};
			hue_rem_s2  <= num_hue[NX-1:QPAD];
			hue_work_s2 <= num_hue[QPAD-1:0];
			hue_den_s2  <= {c_s1, 1'b0};
			bright_s2   <= mx_s1;
			zero_s2     <= (c_s1 == '0);
		end
	end

endmodule

@@ src/rhc_div_step.sv @@
module rhc_div_step #(
	parameter int QPAD = 16
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [rhc_pkg::DEN_W-1:0] rem_in,
	input  logic [QPAD-1:0]           work_in,
	input  logic [rhc_pkg::DEN_W-1:0] den_in,
	output logic [rhc_pkg::DEN_W-1:0] rem_q,
	output logic [QPAD-1:0]           work_q,
	output logic [rhc_pkg::DEN_W-1:0] den_q
);
	import rhc_pkg::*;

	logic [DEN_W-1:0] r;
	logic [DEN_W:0]   trial;
	logic [QPAD-1:0]  w;

	// Restoring division: dividend bits shift out of the top of the work
	// word, quotient bits shift in at the bottom
	always_comb begin
		r = rem_in;
		w = work_in;
		trial = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {r, w[QPAD-1]};
			w = {w[QPAD-2:0], 1'b0};
			if (trial >= {1'b0, den_in}) begin
				r = DEN_W'(trial - {1'b0, den_in});
				w[0] = 1'b1;
			end else begin
				r = trial[DEN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= r;
			work_q <= w;
			den_q  <= den_in;
		end
	end

endmodule

@@ src/rgb_to_hsv_converter_unit.sv @@
// RGB to HSV converter. Takes one 8-bit RGB pixel per clock unless stalled and returns
// brightness (max channel byte), saturation ((max-min)/max scaled so all ones
// is 1.0) and hue in 1/2^HUE_FRAC_BITS degree units below 360 degrees, both
// rounded to nearest. Sustained rate is one pixel per clock while out_ready
// holds; the two pipelined restoring dividers retire four quotient bits per
// stage. Every stage holds its item under output backpressure and empty
// stages fill, so no item is lost or repeated while stalled.
module rgb_to_hsv_converter_unit #(
	parameter int HUE_FRAC_BITS = rhc_pkg::DEF_HUE_FRAC_BITS,
	parameter int SAT_BITS      = rhc_pkg::DEF_SAT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [rhc_pkg::CH_W-1:0] red,
	input  logic [rhc_pkg::CH_W-1:0] green,
	input  logic [rhc_pkg::CH_W-1:0] blue,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [$clog2(rhc_pkg::HUE_DEG_TURN << HUE_FRAC_BITS)-1:0] hue,
	output logic [SAT_BITS-1:0]      saturation,
	output logic [rhc_pkg::CH_W-1:0] brightness
);
	import rhc_pkg::*;

	localparam int HUE_W = $clog2(HUE_DEG_TURN << HUE_FRAC_BITS);
	localparam int QW    = (SAT_BITS > HUE_W) ? SAT_BITS : HUE_W;
	localparam int NSTG  = (QW + STEP_BITS - 1) / STEP_BITS;
	localparam int QPAD  = NSTG * STEP_BITS;
	localparam int STG   = NSTG + 3;
	localparam logic [QPAD-1:0] HUE_TURN = QPAD'(HUE_DEG_TURN << HUE_FRAC_BITS);

	logic [STG-1:0] vld_q;
	logic [STG-1:0] en;

	logic [DEN_W-1:0] sat_rem  [NSTG+1];
	logic [QPAD-1:0]  sat_work [NSTG+1];
	logic [DEN_W-1:0] sat_den  [NSTG+1];
	logic [DEN_W-1:0] hue_rem  [NSTG+1];
	logic [QPAD-1:0]  hue_work [NSTG+1];
	logic [DEN_W-1:0] hue_den  [NSTG+1];
	logic [CH_W-1:0]  bright   [NSTG+1];
	logic             zero     [NSTG+1];

	logic [QPAD-1:0]  hue_wrap;
	logic [HUE_W-1:0] hue_q;
	logic [SAT_BITS-1:0] sat_q;
	logic [CH_W-1:0]  bright_q;

	// Per-stage load enables: a stage loads when empty or when it drains
	always_comb begin
		en[STG-1] = !vld_q[STG-1] || out_ready;
		for (int k = STG - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < STG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[STG-1];

	// Extremes, sector and dividends
	rhc_front #(
		.HUE_FRAC_BITS(HUE_FRAC_BITS),
		.SAT_BITS     (SAT_BITS),
		.QPAD         (QPAD)
	) u_front (
		.clk        (clk),
		.en_s1      (en[0]),
		.en_s2      (en[1]),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.sat_rem_s2 (sat_rem[0]),
		.sat_work_s2(sat_work[0]),
		.sat_den_s2 (sat_den[0]),
		.hue_rem_s2 (hue_rem[0]),
		.hue_work_s2(hue_work[0]),
		.hue_den_s2 (hue_den[0]),
		.bright_s2  (bright[0]),
		.zero_s2    (zero[0])
	);

	// Divider stages, saturation and hue side by side
	for (genvar k = 0; k < NSTG; k++) begin : g_div
		rhc_div_step #(.QPAD(QPAD)) u_sat (
			.clk    (clk),
			.en     (en[k+2]),
			.rem_in (sat_rem[k]),
			.work_in(sat_work[k]),
			.den_in (sat_den[k]),
			.rem_q  (sat_rem[k+1]),
			.work_q (sat_work[k+1]),
			.den_q  (sat_den[k+1])
		);

		rhc_div_step #(.QPAD(QPAD)) u_hue (
			.clk    (clk),
			.en     (en[k+2]),
			.rem_in (hue_rem[k]),
			.work_in(hue_work[k]),
			.den_in (hue_den[k]),
			.rem_q  (hue_rem[k+1]),
			.work_q (hue_work[k+1]),
			.den_q  (hue_den[k+1])
		);

		always_ff @(posedge clk) begin
			if (en[k+2]) begin
				bright[k+1] <= bright[k];
				zero[k+1]   <= zero[k];
			end
		end
	end

	// A hue that rounds up to a full turn reads as zero
	assign hue_wrap = (hue_work[NSTG] >= HUE_TURN) ? hue_work[NSTG] - HUE_TURN
	                                                : hue_work[NSTG];

	// Output register; black and grey pixels give zero hue and saturation
	always_ff @(posedge clk) begin
		if (en[STG-1]) begin
			hue_q    <= zero[NSTG] ? '0 : hue_wrap[HUE_W-1:0];
			sat_q    <= zero[NSTG] ? '0 : sat_work[NSTG][SAT_BITS-1:0];
			bright_q <= bright[NSTG];
		end
	end

	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

endmodule
